// ----- rtl/array_list_engine_defines.svh -----
// assertion macros used by the checker file
`ifndef ARRAY_LIST_ENGINE_DEFINES_SVH
`define ARRAY_LIST_ENGINE_DEFINES_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define ALE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("array_list_engine: same-cycle check failed");

// next-cycle implication, sampled on the rising clock, off during reset
`define ALE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("array_list_engine: next-cycle check failed");

`endif

// ----- rtl/ale_pkg.sv -----
package ale_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int WORD_W    = 32;
    localparam int CNT_W     = 5;
    localparam int POS_W     = 4;
    localparam int IN_W      = 40;
    localparam int OUT_W     = 40;

    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(16);

    typedef enum logic [1:0] {
        ACT_READ   = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_REMOVE = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        PLACE_HEAD = 2'd0,
        PLACE_TAIL = 2'd1,
        PLACE_POS  = 2'd2
    } place_t;

    // controller to datapath
    typedef struct packed {
        logic latch;     // take the new request
        logic rd_src;    // read address: 0 request index, 1 shift source
        logic cap_word;  // capture read data as result word
        logic wr_en;
        logic wr_value;  // write data: 1 request value, 0 read data
        logic step;      // move the shift pointer
        logic finish;    // load the output register
    } ale_cmd_t;

    // datapath to controller
    typedef struct packed {
        action_t new_act;
        logic    new_ok;
        action_t act;
        logic    ok;
        logic    more;
        logic    out_free;
    } ale_sts_t;

endpackage

// ----- rtl/ale_ram.sv -----
module ale_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
)(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/ale_ctrl.sv -----
module ale_ctrl
    import ale_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  ale_sts_t sts,
    output ale_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_CAPT,
        ST_LOOP,
        ST_SHIFT,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.latch = 1'b1;
                    if (!sts.new_ok)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (sts.new_act == ACT_INSERT)
                    begin
                        state_next = ST_LOOP;
                    end
                    else
                    begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH:
            begin
                cmd.rd_src = 1'b0;
                state_next = ST_CAPT;
            end
            ST_CAPT:
            begin
                cmd.cap_word = 1'b1;
                state_next   = (sts.act == ACT_READ) ? ST_DONE : ST_LOOP;
            end
            ST_LOOP:
            begin
                if (sts.more)
                begin
                    cmd.rd_src = 1'b1;
                    state_next = ST_SHIFT;
                end
                else
                begin
                    // pointer sits on the insert slot once the shift is over
                    if (sts.act == ACT_INSERT)
                    begin
                        cmd.wr_en    = 1'b1;
                        cmd.wr_value = 1'b1;
                    end
                    state_next = ST_DONE;
                end
            end
            ST_SHIFT:
            begin
                cmd.wr_en  = 1'b1;
                cmd.step   = 1'b1;
                state_next = ST_LOOP;
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/ale_dpath.sv -----
module ale_dpath
    import ale_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)(
    input  logic             clk,
    input  logic             rst_n,
    input  ale_cmd_t         cmd,
    output ale_sts_t         sts,
    input  logic [IN_W-1:0]  s_tdata,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_data,
    input  logic             m_tready,
    output logic             m_tvalid,
    output logic [OUT_W-1:0] m_tdata
);

    localparam int AW = $clog2(DEPTH);

    action_t           in_act;
    logic [1:0]        in_place;
    logic [POS_W-1:0]  in_pos;
    logic [WORD_W-1:0] in_value;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CNT_W-1:0]  cap_reg;

    action_t           act_reg;
    logic              ok_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic [CNT_W-1:0]  ptr_reg;
    logic [WORD_W-1:0] value_reg;
    logic [WORD_W-1:0] word_reg;

    logic              out_valid_reg;
    logic              status_reg;
    logic [WORD_W-1:0] word_out_reg;
    logic [CNT_W-1:0]  count_out_reg;
    logic              full_reg;

    logic              full_now;
    logic              full_after;
    logic              place_known;
    logic              dec_ok;
    logic [CNT_W-1:0]  dec_idx;
    logic [CNT_W-1:0]  src;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [AW-1:0]     ram_raddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [WORD_W-1:0] ram_rdata;

    assign in_act   = action_t'(s_tdata[1:0]);
    assign in_place = s_tdata[3:2];
    assign in_pos   = s_tdata[7:4];
    assign in_value = s_tdata[39:8];

    // effective capacity is the smaller of the register and the store depth
    assign full_now   = (count_reg >= cap_reg) || (32'(count_reg) >= 32'(DEPTH));
    assign full_after = (count_next >= cap_reg) || (32'(count_next) >= 32'(DEPTH));

    always_comb
    begin
        dec_idx     = '0;
        place_known = 1'b1;
        case (place_t'(in_place))
            PLACE_HEAD: dec_idx = '0;
            PLACE_TAIL: dec_idx = (in_act == ACT_INSERT) ? count_reg
                                                         : count_reg - CNT_W'(1);
            PLACE_POS:  dec_idx = CNT_W'(in_pos);
            default:    place_known = 1'b0;
        endcase

        case (in_act)
            ACT_READ, ACT_REMOVE:
                dec_ok = place_known && (count_reg != '0) && (dec_idx < count_reg);
            ACT_INSERT:
                dec_ok = place_known && !full_now && (dec_idx <= count_reg);
            default:
                dec_ok = 1'b0;
        endcase
    end

    // remove pulls entries down from above, insert pushes them up from below
    assign src = (act_reg == ACT_REMOVE) ? ptr_reg + CNT_W'(1) : ptr_reg - CNT_W'(1);

    always_comb
    begin
        count_next = count_reg;
        case (act_reg)
            ACT_INSERT: count_next = ok_reg ? count_reg + CNT_W'(1) : count_reg;
            ACT_REMOVE: count_next = ok_reg ? count_reg - CNT_W'(1) : count_reg;
            default:    count_next = count_reg;
        endcase
    end

    assign sts.new_act  = in_act;
    assign sts.new_ok   = dec_ok;
    assign sts.act      = act_reg;
    assign sts.ok       = ok_reg;
    assign sts.more     = (act_reg == ACT_REMOVE) ? (src < count_reg) : (ptr_reg > idx_reg);
    assign sts.out_free = !out_valid_reg || m_tready;

    assign ram_we    = cmd.wr_en;
    assign ram_waddr = AW'(ptr_reg);
    assign ram_wdata = cmd.wr_value ? value_reg : ram_rdata;
    assign ram_raddr = cmd.rd_src ? AW'(src) : AW'(idx_reg);

    ale_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            act_reg   <= in_act;
            ok_reg    <= dec_ok;
            idx_reg   <= dec_idx;
            value_reg <= in_value;
            ptr_reg   <= (in_act == ACT_INSERT) ? count_reg : dec_idx;
        end
        else if (cmd.step)
        begin
            ptr_reg <= src;
        end
        if (cmd.cap_word)
        begin
            word_reg <= ram_rdata;
        end
        if (cmd.finish)
        begin
            status_reg    <= !ok_reg;
            word_out_reg  <= (ok_reg && act_reg != ACT_INSERT) ? word_reg : '0;
            count_out_reg <= count_next;
            full_reg      <= full_after;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            cap_reg       <= CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_data;
            end
            if (cmd.finish)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, full_reg, count_out_reg, word_out_reg, status_reg};

endmodule

// ----- rtl/array_list_engine.sv -----
// ordered list of signed 32-bit words in a DEPTH-entry RAM with one write and one
// registered read port. each request reads, inserts or removes at the head, the
// tail or an explicit position and returns one result: status (1 = refused),
// the word read or removed, the count after the request and a full flag.
// requests are served one at a time. a refused request goes straight to the
// output register; inserts and removes move entries one at a time through the RAM
// port, each a read and then a write. a new request is taken while the previous
// result still waits in the output register. the user must write the capacity
// register (reset 16, capped at DEPTH) with cfg_we only while no request is in
// flight; the block does not enforce this. no clearing pass is needed after reset.
module array_list_engine
    import ale_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    // action[1:0], place[3:2], position[7:4], value[39:8]
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // status[0], word_out[32:1], count_out[37:33], is_full[38], zero[39]
    output logic [OUT_W-1:0] m_tdata,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_data
);

    ale_cmd_t cmd;
    ale_sts_t sts;

    ale_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ale_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

endmodule

// ----- rtl/ale_check.sv -----
`include "array_list_engine_defines.svh"

module ale_check
    import ale_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)(
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    // a result waiting on the output holds still
    `ALE_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // one request at a time: the input closes right after a request is taken
    `ALE_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)

    // a refused request never returns a word
    `ALE_ASSERT_NOW(a_refused_zero, m_tvalid && m_tdata[0], m_tdata[32:1] == '0)

    // the count never exceeds the store
    `ALE_ASSERT_NOW(a_count_bound, m_tvalid, 32'(m_tdata[37:33]) <= 32'(DEPTH))

endmodule

bind array_list_engine ale_check #(
    .DEPTH (DEPTH)
) u_ale_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
